// ===== src/stt_pkg.sv =====
package stt_pkg;

    localparam int MaxText   = 64;
    localparam int LineBits  = 24;
    localparam int PrefixLen = 12;
    localparam int KwCount   = 56;
    localparam int QueueDepth = 4;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOS  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text;
        logic [5:0]  ttype;
    } t_rec;

    typedef struct packed {
        logic [2:0]      n;
        t_rec [3:0]      recs;
    } t_bundle;

    localparam logic [5:0] TOK_AND     = 6'd10;
    localparam logic [5:0] TOK_OR      = 6'd11;
    localparam logic [5:0] TOK_NOT     = 6'd12;
    localparam logic [5:0] TOK_IDENT   = 6'd28;
    localparam logic [5:0] TOK_HEX     = 6'd29;
    localparam logic [5:0] TOK_NUMBER  = 6'd30;
    localparam logic [5:0] TOK_STRING  = 6'd31;
    localparam logic [5:0] TOK_PLUS    = 6'd32;
    localparam logic [5:0] TOK_ARROW   = 6'd33;
    localparam logic [5:0] TOK_MINUS   = 6'd34;
    localparam logic [5:0] TOK_STAR    = 6'd35;
    localparam logic [5:0] TOK_DIV     = 6'd36;
    localparam logic [5:0] TOK_MOD     = 6'd37;
    localparam logic [5:0] TOK_EQ      = 6'd38;
    localparam logic [5:0] TOK_ASSIGN  = 6'd39;
    localparam logic [5:0] TOK_NE      = 6'd40;
    localparam logic [5:0] TOK_LE      = 6'd41;
    localparam logic [5:0] TOK_SHL     = 6'd42;
    localparam logic [5:0] TOK_LT      = 6'd43;
    localparam logic [5:0] TOK_GE      = 6'd44;
    localparam logic [5:0] TOK_SHR     = 6'd45;
    localparam logic [5:0] TOK_GT      = 6'd46;
    localparam logic [5:0] TOK_AMP     = 6'd47;
    localparam logic [5:0] TOK_PIPE    = 6'd48;
    localparam logic [5:0] TOK_CARET   = 6'd49;
    localparam logic [5:0] TOK_TILDE   = 6'd50;
    localparam logic [5:0] TOK_LPAREN  = 6'd51;
    localparam logic [5:0] TOK_RPAREN  = 6'd52;
    localparam logic [5:0] TOK_LBRACE  = 6'd53;
    localparam logic [5:0] TOK_RBRACE  = 6'd54;
    localparam logic [5:0] TOK_LBRACK  = 6'd55;
    localparam logic [5:0] TOK_RBRACK  = 6'd56;
    localparam logic [5:0] TOK_SEMI    = 6'd57;
    localparam logic [5:0] TOK_COMMA   = 6'd58;
    localparam logic [5:0] TOK_DOT     = 6'd59;
    localparam logic [5:0] TOK_COLON   = 6'd60;
    localparam logic [5:0] TOK_UNKNOWN = 6'd61;

    localparam logic [6:0] PAIR_NONE = 7'h7F;

    localparam logic [95:0] KW_TEXT [KwCount] = '{
        96'("let"), 96'("decreto"), 96'("fn"), 96'("cancion"),
        96'("return"), 96'("retorno"), 96'("if"), 96'("si"),
        96'("else"), 96'("sino"), 96'("while"), 96'("mientras"),
        96'("for"), 96'("para"), 96'("until"), 96'("hasta"),
        96'("break"), 96'("romper"), 96'("continue"), 96'("continuar"),
        96'("and"), 96'("y"), 96'("or"), 96'("o"),
        96'("not"), 96'("no"), 96'("int"), 96'("entero"),
        96'("byte"), 96'("octeto"), 96'("string"), 96'("cadena"),
        96'("void"), 96'("vacio"), 96'("bool"), 96'("booleano"),
        96'("struct"), 96'("estructura"), 96'("sizeof"), 96'("tamano"),
        96'("null"), 96'("nulo"), 96'("new"), 96'("nuevo"),
        96'("free"), 96'("liberar"), 96'({"escribir", "_sys"}), 96'({"sys_", "write"}),
        96'({"leer", "_sys"}), 96'({"sys_", "read"}), 96'({"abrir", "_sys"}),
        96'({"sys_", "open"}), 96'({"cerrar", "_sys"}), 96'({"sys_", "close"}),
        96'({"salir", "_sys"}), 96'({"sys_", "exit"})
    };

    localparam logic [3:0] KW_LEN [KwCount] = '{
        4'd3, 4'd7, 4'd2, 4'd7, 4'd6, 4'd7, 4'd2, 4'd2,
        4'd4, 4'd4, 4'd5, 4'd8, 4'd3, 4'd4, 4'd5, 4'd5,
        4'd5, 4'd6, 4'd8, 4'd9, 4'd3, 4'd1, 4'd2, 4'd1,
        4'd3, 4'd2, 4'd3, 4'd6, 4'd4, 4'd6, 4'd6, 4'd6,
        4'd4, 4'd5, 4'd4, 4'd8, 4'd6, 4'd10, 4'd6, 4'd6,
        4'd4, 4'd4, 4'd3, 4'd5, 4'd4, 4'd7, 4'd12, 4'd9,
        4'd8, 4'd8, 4'd9, 4'd8, 4'd10, 4'd9, 4'd9, 4'd8
    };

    // The candidate holds the word right-justified, first byte most significant.
    function automatic logic [5:0] kw_lookup(input logic [95:0] cand, input logic [3:0] len);
        logic [5:0] res;
        res = TOK_IDENT;
        for (int i = 0; i < KwCount; i++) begin
            if (KW_LEN[i] == len && KW_TEXT[i] == cand) begin
                res = 6'(i / 2);
            end
        end
        return res;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == "_";
    endfunction

    function automatic logic may_pair(input logic [7:0] b);
        return b == "-" || b == "=" || b == "!" || b == "<" || b == ">" ||
               b == "&" || b == "|" || b == "/";
    endfunction

    function automatic logic [5:0] single_type(input logic [7:0] b);
        logic [5:0] t;
        case (b)
            "+": t = TOK_PLUS;
            "-": t = TOK_MINUS;
            "*": t = TOK_STAR;
            "/": t = TOK_DIV;
            "%": t = TOK_MOD;
            "=": t = TOK_ASSIGN;
            "!": t = TOK_NOT;
            "<": t = TOK_LT;
            ">": t = TOK_GT;
            "&": t = TOK_AMP;
            "|": t = TOK_PIPE;
            "^": t = TOK_CARET;
            "~": t = TOK_TILDE;
            "(": t = TOK_LPAREN;
            ")": t = TOK_RPAREN;
            "{": t = TOK_LBRACE;
            "}": t = TOK_RBRACE;
            "[": t = TOK_LBRACK;
            "]": t = TOK_RBRACK;
            ";": t = TOK_SEMI;
            ",": t = TOK_COMMA;
            ".": t = TOK_DOT;
            ":": t = TOK_COLON;
            default: t = TOK_UNKNOWN;
        endcase
        return t;
    endfunction

    function automatic logic [6:0] pair_type(input logic [7:0] h, input logic [7:0] b);
        logic [6:0] t;
        t = PAIR_NONE;
        if (h == "-" && b == ">") t = {1'b0, TOK_ARROW};
        if (h == "=" && b == "=") t = {1'b0, TOK_EQ};
        if (h == "!" && b == "=") t = {1'b0, TOK_NE};
        if (h == "<" && b == "=") t = {1'b0, TOK_LE};
        if (h == "<" && b == "<") t = {1'b0, TOK_SHL};
        if (h == ">" && b == "=") t = {1'b0, TOK_GE};
        if (h == ">" && b == ">") t = {1'b0, TOK_SHR};
        if (h == "&" && b == "&") t = {1'b0, TOK_AND};
        if (h == "|" && b == "|") t = {1'b0, TOK_OR};
        return t;
    endfunction

endpackage

// ===== src/stt_ifs.sv =====
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink (input valid, input src_byte, output ready);
endinterface

interface stt_out_if #(parameter int LINE_BITS = stt_pkg::LineBits);
    logic                 valid;
    logic                 ready;
    logic [1:0]           record_kind;
    logic [7:0]           text_byte;
    logic [5:0]           token_type;
    logic [LINE_BITS-1:0] line_number;
    logic                 last_of_run;

    modport source (output valid, output record_kind, output text_byte, output token_type,
                    output line_number, output last_of_run, input ready);
    modport sink (input valid, input record_kind, input text_byte, input token_type,
                  input line_number, input last_of_run, output ready);
endinterface

// ===== src/source_text_tokenizer.sv =====
// Each source byte is classified in the cycle it is accepted and its words are written to the
// output queue at that same edge; the output side then loads them into its own register to present them.
// One byte is taken per cycle while the four-entry queue has room; the output side sends
// one word per cycle while the sink is ready, so the words of one byte go out one after another.
// Synchronous active-low reset returns the scanner to idle with the line count at one.
module source_text_tokenizer #(
    parameter int MAX_TEXT  = stt_pkg::MaxText,
    parameter int LINE_BITS = stt_pkg::LineBits
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_in_if.sink     i_src,
    stt_out_if.source  o_tok
);

    logic                 w_push;
    logic                 w_pop;
    logic                 w_q_full;
    logic                 w_q_empty;
    logic                 w_back_busy;
    stt_pkg::t_bundle     w_f_bundle;
    stt_pkg::t_bundle     w_q_bundle;
    logic [LINE_BITS-1:0] w_f_line;
    logic [LINE_BITS-1:0] w_q_line;

    stt_front #(.MAX_TEXT(MAX_TEXT), .LINE_BITS(LINE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src(i_src), .i_full(w_q_full),
        .o_push(w_push), .o_bundle(w_f_bundle), .o_line(w_f_line)
    );

    stt_queue #(.LINE_BITS(LINE_BITS)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_bundle(w_f_bundle),
        .i_line(w_f_line), .i_pop(w_pop), .o_full(w_q_full), .o_empty(w_q_empty),
        .o_bundle(w_q_bundle), .o_line(w_q_line)
    );

    stt_back #(.LINE_BITS(LINE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_q_empty), .i_bundle(w_q_bundle),
        .i_line(w_q_line), .o_pop(w_pop), .o_busy(w_back_busy), .o_tok(o_tok)
    );

    a_end_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.record_kind == stt_pkg::KIND_END |-> o_tok.line_number != '0)
        else $error("token end word carries line zero");

    a_text_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && o_tok.record_kind != stt_pkg::KIND_TEXT |-> o_tok.text_byte == 8'd0)
        else $error("non-text word carries a text byte");

    a_eos_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_src.valid && i_src.ready && i_src.src_byte == 8'd0 |=> !w_q_empty || w_back_busy)
        else $error("end of source produced no word");

endmodule

// ===== src/stt_front.sv =====
module stt_front #(
    parameter int MAX_TEXT  = stt_pkg::MaxText,
    parameter int LINE_BITS = stt_pkg::LineBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    stt_in_if.sink               i_src,
    input  logic                 i_full,
    output logic                 o_push,
    output stt_pkg::t_bundle     o_bundle,
    output logic [LINE_BITS-1:0] o_line
);

    localparam int CW = $clog2(MAX_TEXT);
    localparam logic [CW-1:0] CntLim = CW'(MAX_TEXT - 1);
    localparam logic [CW-1:0] PreLim = CW'(stt_pkg::PrefixLen);

    typedef enum logic [4:0] {
        M_IDLE, M_IDENT, M_NUM0, M_DEC, M_HEX, M_STR, M_STR_ESC, M_CHR_OPEN,
        M_CHR_ESC, M_CHR_CLOSE, M_OP, M_LINE_CMT, M_BLK, M_BLK_STAR
    } t_mode;

    typedef struct packed {
        logic [2:0]         n;
        stt_pkg::t_rec [3:0] recs;
        t_mode              mode;
        logic [7:0]         held;
        logic [CW-1:0]      cnt;
        logic               cut;
        logic               pw_en;
        logic [3:0]         pw_idx;
        logic [7:0]         pw_data;
        logic               line_inc;
    } t_acc;

    t_mode                r_mode;
    logic [7:0]           r_held;
    logic [CW-1:0]        r_cnt;
    logic                 r_cut;
    logic [LINE_BITS-1:0] r_line;
    logic [7:0]           r_prefix [stt_pkg::PrefixLen];

    t_acc        w_acc;
    logic [95:0] w_cand;
    logic [5:0]  w_word_type;
    logic        w_accept;

    function automatic t_acc f_put(input t_acc a, input stt_pkg::t_kind k,
                                   input logic [7:0] text, input logic [5:0] ttype);
        t_acc r;
        r = a;
        r.recs[r.n[1:0]] = '{kind: k, text: text, ttype: ttype};
        r.n = r.n + 3'd1;
        return r;
    endfunction

    function automatic t_acc f_emit(input t_acc a, input logic [7:0] b);
        t_acc r;
        r = a;
        if (!r.cut && r.cnt < CntLim) begin
            if (r.cnt < PreLim) begin
                r.pw_en = 1'b1;
                r.pw_idx = r.cnt[3:0];
                r.pw_data = b;
            end
            r = f_put(r, stt_pkg::KIND_TEXT, b, 6'd0);
            r.cnt = r.cnt + 1'b1;
        end
        return r;
    endfunction

    function automatic t_acc f_end(input t_acc a, input logic [5:0] t);
        t_acc r;
        r = f_put(a, stt_pkg::KIND_END, 8'd0, t);
        r.cnt = '0;
        r.cut = 1'b0;
        r.mode = M_IDLE;
        return r;
    endfunction

    function automatic t_acc f_fresh(input t_acc a, input logic [7:0] b);
        t_acc r;
        r = a;
        r.mode = M_IDLE;
        if (stt_pkg::is_space(b)) begin
            if (b == 8'h0A) r.line_inc = 1'b1;
        end else if (stt_pkg::is_alpha(b) || b == "_") begin
            r.mode = M_IDENT;
            r = f_emit(r, b);
        end else if (stt_pkg::is_digit(b)) begin
            r.mode = (b == "0") ? M_NUM0 : M_DEC;
            r = f_emit(r, b);
        end else if (b == "\"") begin
            r.mode = M_STR;
        end else if (b == 8'h27) begin
            r.mode = M_CHR_OPEN;
        end else if (stt_pkg::may_pair(b)) begin
            r.mode = M_OP;
            r.held = b;
        end else begin
            r = f_emit(r, b);
            r = f_end(r, stt_pkg::single_type(b));
        end
        return r;
    endfunction

    always_comb begin
        w_cand = '0;
        for (int k = 0; k < stt_pkg::PrefixLen; k++) begin
            if (CW'(k) < r_cnt) w_cand = {w_cand[87:0], r_prefix[k]};
        end
        w_word_type = (r_cnt > PreLim) ? stt_pkg::TOK_IDENT
                                       : stt_pkg::kw_lookup(w_cand, r_cnt[3:0]);
    end

    always_comb begin
        logic [7:0] b;
        logic [6:0] pt;
        b = i_src.src_byte;
        pt = stt_pkg::pair_type(r_held, b);
        w_acc = '{n: 3'd0, recs: '0, mode: r_mode, held: r_held, cnt: r_cnt, cut: r_cut,
                  pw_en: 1'b0, pw_idx: 4'd0, pw_data: 8'd0, line_inc: 1'b0};
        if (b == 8'd0) begin
            case (r_mode)
                M_IDENT: w_acc = f_end(w_acc, w_word_type);
                M_NUM0, M_DEC: w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                M_HEX: w_acc = f_end(w_acc, stt_pkg::TOK_HEX);
                M_STR: w_acc = f_end(w_acc, stt_pkg::TOK_STRING);
                M_STR_ESC: begin
                    w_acc = f_emit(w_acc, "\\");
                    w_acc = f_end(w_acc, stt_pkg::TOK_STRING);
                end
                M_CHR_OPEN, M_CHR_ESC, M_CHR_CLOSE: w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                M_OP: begin
                    w_acc = f_emit(w_acc, r_held);
                    w_acc = f_end(w_acc, stt_pkg::single_type(r_held));
                end
                default: ;
            endcase
            w_acc = f_put(w_acc, stt_pkg::KIND_EOS, 8'd0, 6'd0);
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (stt_pkg::is_word(b)) begin
                        w_acc = f_emit(w_acc, b);
                    end else begin
                        w_acc = f_end(w_acc, w_word_type);
                        w_acc = f_fresh(w_acc, b);
                    end
                end
                M_NUM0: begin
                    if (b == "x" || b == "X") begin
                        w_acc = f_emit(w_acc, b);
                        w_acc.mode = M_HEX;
                    end else if (stt_pkg::is_digit(b)) begin
                        w_acc = f_emit(w_acc, b);
                        w_acc.mode = M_DEC;
                    end else begin
                        w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                        w_acc = f_fresh(w_acc, b);
                    end
                end
                M_DEC: begin
                    if (stt_pkg::is_digit(b)) begin
                        w_acc = f_emit(w_acc, b);
                    end else begin
                        w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                        w_acc = f_fresh(w_acc, b);
                    end
                end
                M_HEX: begin
                    if (stt_pkg::is_hex(b)) begin
                        w_acc = f_emit(w_acc, b);
                    end else begin
                        w_acc = f_end(w_acc, stt_pkg::TOK_HEX);
                        w_acc = f_fresh(w_acc, b);
                    end
                end
                M_STR: begin
                    if (b == "\"") w_acc = f_end(w_acc, stt_pkg::TOK_STRING);
                    else if (b == "\\") w_acc.mode = M_STR_ESC;
                    else w_acc = f_emit(w_acc, b);
                end
                M_STR_ESC: begin
                    w_acc.mode = M_STR;
                    if (b == "0") w_acc.cut = 1'b1;
                    else if (b == "n") w_acc = f_emit(w_acc, 8'h0A);
                    else if (b == "t") w_acc = f_emit(w_acc, 8'h09);
                    else if (b == "r") w_acc = f_emit(w_acc, 8'h0D);
                    else w_acc = f_emit(w_acc, b);
                end
                M_CHR_OPEN: begin
                    if (b == "\\") begin
                        w_acc = f_emit(w_acc, b);
                        w_acc.mode = M_CHR_ESC;
                    end else if (b == 8'h27) begin
                        w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                    end else begin
                        w_acc = f_emit(w_acc, b);
                        w_acc.mode = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC: begin
                    w_acc = f_emit(w_acc, b);
                    w_acc.mode = M_CHR_CLOSE;
                end
                M_CHR_CLOSE: begin
                    w_acc = f_end(w_acc, stt_pkg::TOK_NUMBER);
                    if (b != 8'h27) w_acc = f_fresh(w_acc, b);
                end
                M_OP: begin
                    if (r_held == "/") begin
                        if (b == "/") begin
                            w_acc.mode = M_LINE_CMT;
                        end else if (b == "*") begin
                            w_acc.mode = M_BLK;
                        end else begin
                            w_acc = f_emit(w_acc, "/");
                            w_acc = f_end(w_acc, stt_pkg::TOK_DIV);
                            w_acc = f_fresh(w_acc, b);
                        end
                    end else if (pt != stt_pkg::PAIR_NONE) begin
                        w_acc = f_emit(w_acc, r_held);
                        w_acc = f_emit(w_acc, b);
                        w_acc = f_end(w_acc, pt[5:0]);
                    end else begin
                        w_acc = f_emit(w_acc, r_held);
                        w_acc = f_end(w_acc, stt_pkg::single_type(r_held));
                        w_acc = f_fresh(w_acc, b);
                    end
                end
                M_LINE_CMT: begin
                    if (b == 8'h0A) begin
                        w_acc.line_inc = 1'b1;
                        w_acc.mode = M_IDLE;
                    end
                end
                M_BLK: begin
                    if (b == "*") w_acc.mode = M_BLK_STAR;
                    else if (b == 8'h0A) w_acc.line_inc = 1'b1;
                end
                M_BLK_STAR: begin
                    if (b == "/") begin
                        w_acc.mode = M_IDLE;
                    end else if (b != "*") begin
                        if (b == 8'h0A) w_acc.line_inc = 1'b1;
                        w_acc.mode = M_BLK;
                    end
                end
                default: w_acc = f_fresh(w_acc, b);
            endcase
        end
    end

    assign i_src.ready = !i_full;
    assign w_accept = i_src.valid && !i_full;
    assign o_push = w_accept && (w_acc.n != 3'd0);
    assign o_bundle = '{n: w_acc.n, recs: w_acc.recs};
    assign o_line = r_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_held <= 8'd0;
            r_cnt <= '0;
            r_cut <= 1'b0;
            r_line <= LINE_BITS'(1);
        end else if (w_accept) begin
            if (i_src.src_byte == 8'd0) begin
                r_mode <= M_IDLE;
                r_held <= 8'd0;
                r_cnt <= '0;
                r_cut <= 1'b0;
                r_line <= LINE_BITS'(1);
            end else begin
                r_mode <= w_acc.mode;
                r_held <= w_acc.held;
                r_cnt <= w_acc.cnt;
                r_cut <= w_acc.cut;
                if (w_acc.line_inc && r_line != '1) r_line <= r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_acc.pw_en) r_prefix[w_acc.pw_idx] <= w_acc.pw_data;
    end

endmodule

// ===== src/stt_queue.sv =====
module stt_queue #(
    parameter int LINE_BITS = stt_pkg::LineBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  stt_pkg::t_bundle     i_bundle,
    input  logic [LINE_BITS-1:0] i_line,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output stt_pkg::t_bundle     o_bundle,
    output logic [LINE_BITS-1:0] o_line
);

    localparam int AW = $clog2(stt_pkg::QueueDepth);

    stt_pkg::t_bundle     r_bnd [stt_pkg::QueueDepth];
    logic [LINE_BITS-1:0] r_lin [stt_pkg::QueueDepth];
    logic [AW-1:0]        r_wr;
    logic [AW-1:0]        r_rd;
    logic [AW:0]          r_cnt;

    assign o_full = r_cnt == (AW+1)'(stt_pkg::QueueDepth);
    assign o_empty = r_cnt == '0;
    assign o_bundle = r_bnd[r_rd];
    assign o_line = r_lin[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_bnd[r_wr] <= i_bundle;
            r_lin[r_wr] <= i_line;
        end
    end

endmodule

// ===== src/stt_back.sv =====
module stt_back #(
    parameter int LINE_BITS = stt_pkg::LineBits
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  stt_pkg::t_bundle     i_bundle,
    input  logic [LINE_BITS-1:0] i_line,
    output logic                 o_pop,
    output logic                 o_busy,
    stt_out_if.source            o_tok
);

    logic                 r_have;
    logic [1:0]           r_idx;
    stt_pkg::t_bundle     r_bnd;
    logic [LINE_BITS-1:0] r_line;

    stt_pkg::t_rec w_rec;
    logic          w_fire;
    logic          w_last;

    assign w_rec = r_bnd.recs[r_idx];
    assign w_fire = r_have && o_tok.ready;
    assign w_last = {1'b0, r_idx} == (r_bnd.n - 3'd1);
    assign o_pop = !i_empty && (!r_have || (w_fire && w_last));
    assign o_busy = r_have;

    assign o_tok.valid = r_have;
    assign o_tok.record_kind = w_rec.kind;
    assign o_tok.text_byte = w_rec.text;
    assign o_tok.token_type = w_rec.ttype;
    assign o_tok.line_number = (w_rec.kind == stt_pkg::KIND_END) ? r_line : '0;
    assign o_tok.last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx <= 2'd0;
        end else if (o_pop) begin
            r_have <= 1'b1;
            r_idx <= 2'd0;
        end else if (w_fire) begin
            if (w_last) r_have <= 1'b0;
            else r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bnd <= i_bundle;
            r_line <= i_line;
        end
    end

endmodule

// ===== test/tb_source_text_tokenizer.sv =====
`timescale 1ns / 1ps

class tok_scoreboard;
    typedef enum {
        S_IDLE, S_IDENT, S_NUM0, S_DEC, S_HEX, S_STR, S_STR_ESC, S_CHR_OPEN,
        S_CHR_ESC, S_CHR_CLOSE, S_OP, S_LINE_CMT, S_BLK, S_BLK_STAR
    } scan_e;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  text;
        logic [5:0]  ttype;
        logic [23:0] line;
        logic        last;
    } word_t;

    localparam logic [5:0] NO_PAIR = 6'h3F;

    string kw_words[56] = '{
        "let", "decreto", "fn", "cancion", "return", "retorno", "if", "si",
        "else", "sino", "while", "mientras", "for", "para", "until", "hasta",
        "break", "romper", "continue", "continuar", "and", "y", "or", "o",
        "not", "no", "int", "entero", "byte", "octeto", "string", "cadena",
        "void", "vacio", "bool", "booleano", "struct", "estructura", "sizeof", "tamano",
        "null", "nulo", "new", "nuevo", "free", "liberar",
        string'({"escribir", "_sys"}), string'({"sys_", "write"}),
        string'({"leer", "_sys"}), string'({"sys_", "read"}),
        string'({"abrir", "_sys"}), string'({"sys_", "open"}),
        string'({"cerrar", "_sys"}), string'({"sys_", "close"}),
        string'({"salir", "_sys"}), string'({"sys_", "exit"})
    };

    word_t       expected_words[$];
    word_t       step_words[$];
    int          errors;
    scan_e       mode;
    logic [7:0]  held;
    int          text_len;
    logic [7:0]  prefix[12];
    logic [23:0] line;
    bit          cut;

    function new();
        errors = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        mode = S_IDLE;
        held = 8'd0;
        text_len = 0;
        line = 24'd1;
        cut = 1'b0;
        foreach (prefix[i]) prefix[i] = 8'd0;
    endfunction

    function bit is_space(logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function bit is_hexdig(logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function bit is_wordch(logic [7:0] b);
        return is_alpha(b) || is_digit(b) || b == "_";
    endfunction

    function bit starts_pair(logic [7:0] b);
        return b == "-" || b == "=" || b == "!" || b == "<" || b == ">" ||
               b == "&" || b == "|" || b == "/";
    endfunction

    function void put(logic [1:0] kind, logic [7:0] text, logic [5:0] ttype,
                      logic [23:0] ln);
        word_t w;
        w.kind = kind;
        w.text = text;
        w.ttype = ttype;
        w.line = ln;
        w.last = 1'b0;
        if (step_words.size() < 4) step_words.push_back(w);
    endfunction

    function void bump_line();
        if (line != 24'hFFFFFF) line++;
    endfunction

    function void add_text(logic [7:0] b);
        if (!cut && text_len < stt_pkg::MaxText - 1) begin
            if (text_len < 12) prefix[text_len] = b;
            put(stt_pkg::KIND_TEXT, b, 6'd0, 24'd0);
            text_len++;
        end
    endfunction

    function void close_token(logic [5:0] t);
        put(stt_pkg::KIND_END, 8'd0, t, line);
        text_len = 0;
        cut = 1'b0;
        mode = S_IDLE;
    endfunction

    function logic [5:0] classify_word();
        string s;
        s = "";
        if (text_len > 12) return stt_pkg::TOK_IDENT;
        for (int i = 0; i < text_len; i++) s = {s, string'(prefix[i])};
        foreach (kw_words[k]) begin
            if (kw_words[k] == s) return 6'(k / 2);
        end
        return stt_pkg::TOK_IDENT;
    endfunction

    function logic [5:0] op_type(logic [7:0] b);
        case (b)
            "+": return stt_pkg::TOK_PLUS;
            "-": return stt_pkg::TOK_MINUS;
            "*": return stt_pkg::TOK_STAR;
            "/": return stt_pkg::TOK_DIV;
            "%": return stt_pkg::TOK_MOD;
            "=": return stt_pkg::TOK_ASSIGN;
            "!": return stt_pkg::TOK_NOT;
            "<": return stt_pkg::TOK_LT;
            ">": return stt_pkg::TOK_GT;
            "&": return stt_pkg::TOK_AMP;
            "|": return stt_pkg::TOK_PIPE;
            "^": return stt_pkg::TOK_CARET;
            "~": return stt_pkg::TOK_TILDE;
            "(": return stt_pkg::TOK_LPAREN;
            ")": return stt_pkg::TOK_RPAREN;
            "{": return stt_pkg::TOK_LBRACE;
            "}": return stt_pkg::TOK_RBRACE;
            "[": return stt_pkg::TOK_LBRACK;
            "]": return stt_pkg::TOK_RBRACK;
            ";": return stt_pkg::TOK_SEMI;
            ",": return stt_pkg::TOK_COMMA;
            ".": return stt_pkg::TOK_DOT;
            ":": return stt_pkg::TOK_COLON;
            default: return stt_pkg::TOK_UNKNOWN;
        endcase
    endfunction

    function logic [5:0] two_char_type(logic [7:0] h, logic [7:0] b);
        if (h == "-" && b == ">") return stt_pkg::TOK_ARROW;
        if (h == "=" && b == "=") return stt_pkg::TOK_EQ;
        if (h == "!" && b == "=") return stt_pkg::TOK_NE;
        if (h == "<" && b == "=") return stt_pkg::TOK_LE;
        if (h == "<" && b == "<") return stt_pkg::TOK_SHL;
        if (h == ">" && b == "=") return stt_pkg::TOK_GE;
        if (h == ">" && b == ">") return stt_pkg::TOK_SHR;
        if (h == "&" && b == "&") return stt_pkg::TOK_AND;
        if (h == "|" && b == "|") return stt_pkg::TOK_OR;
        return NO_PAIR;
    endfunction

    function void start_token(logic [7:0] b);
        mode = S_IDLE;
        if (is_space(b)) begin
            if (b == 8'h0A) bump_line();
        end else if (is_alpha(b) || b == "_") begin
            mode = S_IDENT;
            add_text(b);
        end else if (is_digit(b)) begin
            mode = (b == "0") ? S_NUM0 : S_DEC;
            add_text(b);
        end else if (b == 8'h22) begin
            mode = S_STR;
        end else if (b == 8'h27) begin
            mode = S_CHR_OPEN;
        end else if (starts_pair(b)) begin
            mode = S_OP;
            held = b;
        end else begin
            add_text(b);
            close_token(op_type(b));
        end
    endfunction

    function void end_source();
        case (mode)
            S_IDENT: close_token(classify_word());
            S_NUM0, S_DEC: close_token(stt_pkg::TOK_NUMBER);
            S_HEX: close_token(stt_pkg::TOK_HEX);
            S_STR: close_token(stt_pkg::TOK_STRING);
            S_STR_ESC: begin
                add_text(8'h5C);
                close_token(stt_pkg::TOK_STRING);
            end
            S_CHR_OPEN, S_CHR_ESC, S_CHR_CLOSE: close_token(stt_pkg::TOK_NUMBER);
            S_OP: begin
                add_text(held);
                close_token(op_type(held));
            end
            default: ;
        endcase
        put(stt_pkg::KIND_EOS, 8'd0, 6'd0, 24'd0);
        clear_scan();
    endfunction

    function void note_byte(logic [7:0] b);
        logic [5:0] t;
        step_words.delete();
        if (b == 8'd0) begin
            end_source();
        end else begin
            case (mode)
                S_IDENT: begin
                    if (is_wordch(b)) add_text(b);
                    else begin
                        close_token(classify_word());
                        start_token(b);
                    end
                end
                S_NUM0: begin
                    if (b == "x" || b == "X") begin
                        add_text(b);
                        mode = S_HEX;
                    end else if (is_digit(b)) begin
                        add_text(b);
                        mode = S_DEC;
                    end else begin
                        close_token(stt_pkg::TOK_NUMBER);
                        start_token(b);
                    end
                end
                S_DEC: begin
                    if (is_digit(b)) add_text(b);
                    else begin
                        close_token(stt_pkg::TOK_NUMBER);
                        start_token(b);
                    end
                end
                S_HEX: begin
                    if (is_hexdig(b)) add_text(b);
                    else begin
                        close_token(stt_pkg::TOK_HEX);
                        start_token(b);
                    end
                end
                S_STR: begin
                    if (b == 8'h22) close_token(stt_pkg::TOK_STRING);
                    else if (b == 8'h5C) mode = S_STR_ESC;
                    else add_text(b);
                end
                S_STR_ESC: begin
                    mode = S_STR;
                    if (b == "0") cut = 1'b1;
                    else if (b == "n") add_text(8'h0A);
                    else if (b == "t") add_text(8'h09);
                    else if (b == "r") add_text(8'h0D);
                    else add_text(b);
                end
                S_CHR_OPEN: begin
                    if (b == 8'h5C) begin
                        add_text(b);
                        mode = S_CHR_ESC;
                    end else if (b == 8'h27) begin
                        close_token(stt_pkg::TOK_NUMBER);
                    end else begin
                        add_text(b);
                        mode = S_CHR_CLOSE;
                    end
                end
                S_CHR_ESC: begin
                    add_text(b);
                    mode = S_CHR_CLOSE;
                end
                S_CHR_CLOSE: begin
                    close_token(stt_pkg::TOK_NUMBER);
                    if (b != 8'h27) start_token(b);
                end
                S_OP: begin
                    if (held == "/") begin
                        if (b == "/") mode = S_LINE_CMT;
                        else if (b == "*") mode = S_BLK;
                        else begin
                            add_text("/");
                            close_token(stt_pkg::TOK_DIV);
                            start_token(b);
                        end
                    end else begin
                        t = two_char_type(held, b);
                        if (t != NO_PAIR) begin
                            add_text(held);
                            add_text(b);
                            close_token(t);
                        end else begin
                            add_text(held);
                            close_token(op_type(held));
                            start_token(b);
                        end
                    end
                end
                S_LINE_CMT: begin
                    if (b == 8'h0A) begin
                        bump_line();
                        mode = S_IDLE;
                    end
                end
                S_BLK: begin
                    if (b == "*") mode = S_BLK_STAR;
                    else if (b == 8'h0A) bump_line();
                end
                S_BLK_STAR: begin
                    if (b == "/") mode = S_IDLE;
                    else if (b != "*") begin
                        if (b == 8'h0A) bump_line();
                        mode = S_BLK;
                    end
                end
                default: start_token(b);
            endcase
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void check_word(logic [1:0] kind, logic [7:0] text, logic [5:0] ttype,
                             logic [23:0] ln, logic last);
        word_t got;
        word_t e;
        got.kind = kind;
        got.text = text;
        got.ttype = ttype;
        got.line = ln;
        got.last = last;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word kind=%0d text=%h type=%0d line=%0d last=%0d",
                     $realtime, got.kind, got.text, got.ttype, got.line, got.last);
            errors++;
            return;
        end
        e = expected_words.pop_front();
        if (got.kind !== e.kind) begin
            $display("%0t: record_kind expected %0d actual %0d", $realtime, e.kind, got.kind);
            errors++;
        end
        if (got.text !== e.text) begin
            $display("%0t: text_byte expected %h actual %h", $realtime, e.text, got.text);
            errors++;
        end
        if (got.ttype !== e.ttype) begin
            $display("%0t: token_type expected %0d actual %0d", $realtime, e.ttype, got.ttype);
            errors++;
        end
        if (got.line !== e.line) begin
            $display("%0t: line_number expected %0d actual %0d", $realtime, e.line, got.line);
            errors++;
        end
        if (got.last !== e.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $realtime, e.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_source_text_tokenizer;
    localparam int IdleLimit = 2000;

    logic i_clk;
    logic i_rst_n;
    stt_in_if  src_if ();
    stt_out_if tok_if ();

    tok_scoreboard sb = new();
    int  bytes_sent;
    int  words_taken;
    int  idle_cycles;
    bit  src_quiet;
    bit  sink_quiet;
    logic [7:0] pend_bytes[$];

    source_text_tokenizer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0) src_quiet = !src_quiet;
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_if.valid <= 1'b1;
        src_if.src_byte <= b;
        do @(posedge i_clk); while (!src_if.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) pend_bytes.push_back(s[i]);
    endtask

    task automatic flush_source();
        pend_bytes.push_back(8'd0);
        while (pend_bytes.size() > 0) send_byte(pend_bytes.pop_front());
    endtask

    task automatic add_fragment();
        int kind;
        int n;
        string s;
        string ops[19] = '{"->", "==", "!=", "<=", "<<", ">=", ">>", "&&", "||",
                           "!", "=", "<", ">", "&", "|", "/", "+", ";", "("};
        string escs[7] = '{"\\n", "\\t", "\\r", "\\\\", "\\\"", "\\0", "\\q"};
        kind = $urandom_range(0, 11);
        case (kind)
            0: add_text(sb.kw_words[$urandom_range(0, 55)]);
            1: begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 75)
                                                 : $urandom_range(1, 10);
                s = "";
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: s = {s, string'(8'($urandom_range("a", "z")))};
                        1: s = {s, string'(8'($urandom_range("A", "Z")))};
                        2: s = {s, (i == 0) ? "_" : string'(8'($urandom_range("0", "9")))};
                        default: s = {s, "_"};
                    endcase
                end
                add_text(s);
            end
            2: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) pend_bytes.push_back(8'($urandom_range("0", "9")));
            end
            3: begin
                add_text($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    s = "0123456789abcdefABCDEF";
                    pend_bytes.push_back(s[$urandom_range(0, 21)]);
                end
            end
            4: begin
                add_text("\"");
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0) add_text(escs[$urandom_range(0, 6)]);
                    else pend_bytes.push_back(8'($urandom_range(32, 126)) == 8'h22 ?
                                              8'h41 : 8'($urandom_range(35, 91)));
                end
                if ($urandom_range(0, 7) != 0) add_text("\"");
            end
            5: begin
                add_text("'");
                if ($urandom_range(0, 2) == 0) add_text("\\");
                if ($urandom_range(0, 5) != 0) pend_bytes.push_back(8'($urandom_range(32, 126)));
                if ($urandom_range(0, 3) != 0) add_text("'");
            end
            6, 7: add_text(ops[$urandom_range(0, 18)]);
            8: begin
                add_text("// c ");
                pend_bytes.push_back(8'($urandom_range(1, 255)) == 8'h0A ? 8'h41 : 8'h2A);
                add_text("\n");
            end
            9: begin
                add_text("/* x");
                if ($urandom_range(0, 1)) add_text("\n*");
                add_text($urandom_range(0, 1) ? "**/" : "*/");
            end
            10: add_text($urandom_range(0, 1) ? "\n" : "\t");
            default: pend_bytes.push_back(8'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(0, 2) == 0) add_text(" ");
    endtask

    initial begin
        string long_word;
        src_if.valid <= 1'b0;
        src_if.src_byte <= 8'd0;
        i_rst_n <= 1'b0;
        bytes_sent = 0;
        src_quiet = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_text("let decreto ");
        add_text(string'({"escribir", "_sys"}));
        add_text(" ");
        add_text(string'({"sys_", "write"}));
        add_text(" continuar y o no _a9 x");
        flush_source();
        add_text("0 0x 0X1fA 123 0x12g");
        flush_source();
        add_text("\"a\\n\\t\\r\\\\\\\"q\\0zz\" \"ab\\");
        flush_source();
        add_text("'a' 'b '\\n' '' '\\'' 'c");
        flush_source();
        add_text("-> == != <= << < >= >> > && || ! = & | / // c\n q /* a\n*b **/");
        add_text(" + % ^ ~ ( ) { } [ ] ; , . : @ #");
        pend_bytes.push_back(8'd128);
        pend_bytes.push_back(8'd255);
        flush_source();
        long_word = "";
        for (int i = 0; i < 70; i++) long_word = {long_word, "k"};
        add_text({long_word, " /* open"});
        flush_source();

        while (bytes_sent < 350) begin
            n_frag_loop();
        end
        src_if.valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("source_text_tokenizer regression: pass");
        end else begin
            $display("source_text_tokenizer regression: fail");
        end
        $finish;
    end

    task automatic n_frag_loop();
        int n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) add_fragment();
        flush_source();
    endtask

    initial begin
        int stall;
        tok_if.ready <= 1'b0;
        words_taken = 0;
        sink_quiet = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
            stall = sink_quiet ? 0 : $urandom_range(0, 12);
            if (words_taken == 150) stall = 400;
            if (stall > 0) begin
                tok_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tok_if.ready <= 1'b1;
            do @(posedge i_clk); while (!tok_if.valid);
            words_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (tok_if.valid && tok_if.ready) begin
                sb.check_word(tok_if.record_kind, tok_if.text_byte, tok_if.token_type,
                              tok_if.line_number, tok_if.last_of_run);
            end
            if ((tok_if.valid && tok_if.ready) || (src_if.valid && src_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IdleLimit) begin
                $display("source_text_tokenizer regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end else begin
            idle_cycles <= 0;
        end
    end
endmodule
